// File: design/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

    localparam int HUE_W      = 16;
    localparam int SQ_W       = 9;
    localparam int CH_W       = 8;

    localparam int HUE_MOD    = 360;
    localparam int SECTOR_DEG = 60;
    localparam int FULL_SCALE = 255;
    localparam int Q_ONE      = 256;
    localparam int Q_FRAC     = 8;

    localparam int NSTG       = 6;

    localparam int HUE_RECIP      = 11651;
    localparam int HUE_RECIP_SH   = 19;
    localparam int FRAC_RECIP     = 4370;
    localparam int FRAC_RECIP_SH  = 16;

    localparam int KQ_ONE     = Q_ONE * SECTOR_DEG;

    typedef enum logic [2:0] {
        SEC_RED_YELLOW,
        SEC_YELLOW_GREEN,
        SEC_GREEN_CYAN,
        SEC_CYAN_BLUE,
        SEC_BLUE_MAGENTA,
        SEC_MAGENTA_RED
    } t_sector;

endpackage

// File: design/hsv_to_rgb_converter.sv
// Channel   Direction  Handshake            Beat fields
// input     in         i_valid / o_ready    i_hue_degrees, i_saturation, i_brightness
// output    out        o_valid / i_ready    o_red, o_green, o_blue
//
// One beat per cycle sustained while i_ready is high.
// Six register stages: hue reduction (two), sector split, term forming,
// three parallel multiplies, divide-by-constant and channel routing.
// Each stage holds independently, so bubbles collapse while the output stalls.
// Synchronous active-low reset clears the stage valid bits only.
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [HUE_W-1:0]     i_hue_degrees,
    input  logic [SQ_W-1:0]      i_saturation,
    input  logic [SQ_W-1:0]      i_brightness,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [CH_W-1:0]      o_red,
    output logic [CH_W-1:0]      o_green,
    output logic [CH_W-1:0]      o_blue
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_adv;

    logic [HUE_W-1:0] r_s1_hue;
    logic [7:0]       r_s1_quot;
    logic [SQ_W-1:0]  r_s1_sat;
    logic [SQ_W-1:0]  r_s1_val;

    logic [8:0]       r_s2_h;
    logic [SQ_W-1:0]  r_s2_sat;
    logic [SQ_W-1:0]  r_s2_val;

    t_sector          r_s3_sector;
    logic [5:0]       r_s3_rem;
    logic [SQ_W-1:0]  r_s3_sat;
    logic [SQ_W-1:0]  r_s3_val;

    t_sector          r_s4_sector;
    logic [15:0]      r_s4_vs;
    logic [SQ_W-1:0]  r_s4_kp;
    logic [13:0]      r_s4_kq;
    logic [13:0]      r_s4_kt;

    t_sector          r_s5_sector;
    logic [29:0]      r_s5_mq;
    logic [29:0]      r_s5_mt;
    logic [CH_W-1:0]  r_s5_cp;
    logic [CH_W-1:0]  r_s5_cv;

    logic [CH_W-1:0]  r_s6_red;
    logic [CH_W-1:0]  r_s6_green;
    logic [CH_W-1:0]  r_s6_blue;

    logic [26:0]      n_hprod;
    logic [SQ_W-1:0]  n_sat;
    logic [SQ_W-1:0]  n_val;
    logic [16:0]      n_hsub;
    t_sector          n_sector;
    logic [8:0]       n_base;
    logic [8:0]       n_remw;
    logic [16:0]      n_vs;
    logic [14:0]      n_srem;
    logic [14:0]      n_scomp;
    logic [5:0]       n_comp;
    logic [24:0]      n_mp;
    logic [24:0]      n_dq;
    logic [24:0]      n_dt;
    logic [CH_W-1:0]  n_cq;
    logic [CH_W-1:0]  n_ct;

    always_comb begin
        n_adv[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            n_adv[k] = !r_vld[k] || n_adv[k+1];
        end
    end

    assign o_ready = n_adv[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (n_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: clamp, hue quotient by 360 as (hue/8)/45 through a reciprocal
    assign n_hprod = 27'(i_hue_degrees[HUE_W-1:3]) * 27'(HUE_RECIP);
    assign n_sat   = (i_saturation > SQ_W'(Q_ONE)) ? SQ_W'(Q_ONE) : i_saturation;
    assign n_val   = (i_brightness > SQ_W'(Q_ONE)) ? SQ_W'(Q_ONE) : i_brightness;

    // stage 2: hue mod 360
    assign n_hsub = 17'(r_s1_hue) - 17'(r_s1_quot) * 17'(HUE_MOD);

    // stage 3: sector and remainder
    always_comb begin
        case (r_s2_h) inside
            [9'd0:9'd59]: begin
                n_sector = SEC_RED_YELLOW;
                n_base   = 9'd0;
            end
            [9'd60:9'd119]: begin
                n_sector = SEC_YELLOW_GREEN;
                n_base   = 9'd60;
            end
            [9'd120:9'd179]: begin
                n_sector = SEC_GREEN_CYAN;
                n_base   = 9'd120;
            end
            [9'd180:9'd239]: begin
                n_sector = SEC_CYAN_BLUE;
                n_base   = 9'd180;
            end
            [9'd240:9'd299]: begin
                n_sector = SEC_BLUE_MAGENTA;
                n_base   = 9'd240;
            end
            default: begin
                n_sector = SEC_MAGENTA_RED;
                n_base   = 9'd300;
            end
        endcase
        n_remw = r_s2_h - n_base;
    end

    // stage 4: 255*v and the p, q, t factors
    assign n_vs    = 17'(r_s3_val) * 17'(FULL_SCALE);
    assign n_comp  = 6'(SECTOR_DEG) - r_s3_rem;
    assign n_srem  = 15'(r_s3_sat) * 15'(r_s3_rem);
    assign n_scomp = 15'(r_s3_sat) * 15'(n_comp);

    // stage 5: products
    assign n_mp = 25'(r_s4_vs) * 25'(r_s4_kp);

    // stage 6: divide by 2^16*60 as ((x >> 18) / 15) through a reciprocal, then route
    assign n_dq = 25'(r_s5_mq[29:18]) * 25'(FRAC_RECIP);
    assign n_dt = 25'(r_s5_mt[29:18]) * 25'(FRAC_RECIP);
    assign n_cq = n_dq[FRAC_RECIP_SH +: CH_W];
    assign n_ct = n_dt[FRAC_RECIP_SH +: CH_W];

    always_ff @(posedge i_clk) begin
        if (n_adv[0]) begin
            r_s1_hue  <= i_hue_degrees;
            r_s1_quot <= n_hprod[HUE_RECIP_SH +: 8];
            r_s1_sat  <= n_sat;
            r_s1_val  <= n_val;
        end
        if (n_adv[1]) begin
            r_s2_h   <= n_hsub[8:0];
            r_s2_sat <= r_s1_sat;
            r_s2_val <= r_s1_val;
        end
        if (n_adv[2]) begin
            r_s3_sector <= n_sector;
            r_s3_rem    <= n_remw[5:0];
            r_s3_sat    <= r_s2_sat;
            r_s3_val    <= r_s2_val;
        end
        if (n_adv[3]) begin
            r_s4_sector <= r_s3_sector;
            r_s4_vs     <= n_vs[15:0];
            r_s4_kp     <= SQ_W'(Q_ONE) - r_s3_sat;
            r_s4_kq     <= 14'(15'(KQ_ONE) - n_srem);
            r_s4_kt     <= 14'(15'(KQ_ONE) - n_scomp);
        end
        if (n_adv[4]) begin
            r_s5_sector <= r_s4_sector;
            r_s5_mq     <= 30'(r_s4_vs) * 30'(r_s4_kq);
            r_s5_mt     <= 30'(r_s4_vs) * 30'(r_s4_kt);
            r_s5_cp     <= n_mp[2*Q_FRAC +: CH_W];
            r_s5_cv     <= r_s4_vs[Q_FRAC +: CH_W];
        end
        if (n_adv[5]) begin
            case (r_s5_sector)
                SEC_YELLOW_GREEN: begin
                    r_s6_red   <= n_cq;
                    r_s6_green <= r_s5_cv;
                    r_s6_blue  <= r_s5_cp;
                end
                SEC_GREEN_CYAN: begin
                    r_s6_red   <= r_s5_cp;
                    r_s6_green <= r_s5_cv;
                    r_s6_blue  <= n_ct;
                end
                SEC_CYAN_BLUE: begin
                    r_s6_red   <= r_s5_cp;
                    r_s6_green <= n_cq;
                    r_s6_blue  <= r_s5_cv;
                end
                SEC_BLUE_MAGENTA: begin
                    r_s6_red   <= n_ct;
                    r_s6_green <= r_s5_cp;
                    r_s6_blue  <= r_s5_cv;
                end
                SEC_MAGENTA_RED: begin
                    r_s6_red   <= r_s5_cv;
                    r_s6_green <= r_s5_cp;
                    r_s6_blue  <= n_cq;
                end
                default: begin
                    r_s6_red   <= r_s5_cv;
                    r_s6_green <= n_ct;
                    r_s6_blue  <= r_s5_cp;
                end
            endcase
        end
    end

    assign o_red   = r_s6_red;
    assign o_green = r_s6_green;
    assign o_blue  = r_s6_blue;

    a_hue_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_s2_h < 9'(HUE_MOD)))
        else $error("reduced hue out of range");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_s3_rem < 6'(SECTOR_DEG)))
        else $error("sector remainder out of range");

    a_q_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r_s4_kq >= 14'(Q_ONE)) && (r_s4_kq <= 14'(KQ_ONE)))
        else $error("q factor out of range");

    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input held while output empty");

endmodule
